// ----- hdl/rcs_pkg.sv -----
// Package for the DRAM RAS/CAS sequencer.
// It holds the request and result types, the operation codes and the register indexes.
// It has no dependencies.
package rcs_pkg;

    localparam int unsigned ADDR_W = 9;
    localparam int unsigned HOLD_W = 8;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_READ    = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ENABLE = 1'd1;

    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 8'd16;

    typedef struct packed {
        logic              start_req;
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] row_addr;
        logic [ADDR_W-1:0] col_addr;
        logic              write_bit;
        logic              dram_dout;
    } in_item_t;

    typedef struct packed {
        logic              ras_n;
        logic              cas_n;
        logic              we_n;
        logic              din;
        logic [ADDR_W-1:0] addr_bus;
        logic              power_pin;
        logic              busy_res;
        logic              read_valid;
        logic              read_bit;
    } out_item_t;

endpackage

// ----- hdl/dram_ras_cas_sequencer_unit.sv -----
// Top level of the DRAM RAS/CAS sequencer: config registers, result register, checks.
// It instantiates rcs_in_stage and rcs_seq and depends on rcs_pkg.
//
// Each request is one tick of the DRAM pin sequencer and returns one result with the
// pin levels after that tick. A request is registered on entry, stepped through the
// phase logic and registered again on exit; a new request is taken every cycle while
// out_stall is low. An access takes 4 (read) or 5 (write) ticks plus hold_ticks, with a
// hold of 0 counting as 1; a refresh takes one start tick plus 2 ticks per row.
module dram_ras_cas_sequencer_unit
#(
    parameter int unsigned ADDR_BITS = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rcs_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rcs_pkg::out_item_t                out_data,
    input  logic                              cfg_wr_en,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                          item_vld;
    rcs_pkg::in_item_t             item;
    logic                          advance;
    rcs_pkg::out_item_t            result;
    logic                          out_vld_reg, out_vld_next;
    rcs_pkg::out_item_t            out_data_reg;
    logic [rcs_pkg::HOLD_W-1:0]    hold_ticks_reg;
    logic                          power_enable_reg;

    assign advance      = item_vld && (!out_vld_reg || !out_stall);
    assign out_vld_next = advance || (out_vld_reg && out_stall);
    assign out_valid    = out_vld_reg;
    assign out_data     = out_data_reg;

    rcs_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    rcs_seq #(
        .ADDR_BITS (ADDR_BITS)
    ) u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (item),
        .hold_ticks   (hold_ticks_reg),
        .power_enable (power_enable_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg   <= rcs_pkg::HOLD_TICKS_RESET;
            power_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rcs_pkg::REG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data;
                rcs_pkg::REG_POWER_ENABLE: power_enable_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // a sampled read bit ends the access: strobes released, sequencer idle
    a_read_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_data_reg.read_valid |->
            out_data_reg.ras_n && out_data_reg.cas_n && !out_data_reg.busy_res)
        else $error("read sampled outside release tick");

    // CAS never goes low without RAS low
    a_cas_under_ras: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_data_reg.cas_n |-> !out_data_reg.ras_n)
        else $error("CAS low while RAS high");

    // a held request blocks the input only while the result side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_vld && out_vld_reg && out_stall)
        else $error("input stalled without cause");

endmodule

// ----- hdl/rcs_in_stage.sv -----
// Input register of the DRAM RAS/CAS sequencer.
// It captures one request and holds it until the sequencer advances.
// It depends on rcs_pkg.
module rcs_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rcs_pkg::in_item_t in_data,
    input  logic              advance,
    output logic              item_vld,
    output rcs_pkg::in_item_t item
);

    logic              vld_reg;
    logic              vld_next;
    logic              load;
    rcs_pkg::in_item_t data_reg;

    assign in_stall = vld_reg && !advance;
    assign load     = in_valid && !in_stall;
    assign vld_next = load || (vld_reg && !advance);
    assign item_vld = vld_reg;
    assign item     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// ----- hdl/rcs_seq.sv -----
// Pin sequencer of the DRAM RAS/CAS sequencer: phase state and pin levels.
// One step per request; the result is the pin levels after that tick.
// It depends on rcs_pkg.
module rcs_seq
#(
    parameter int unsigned ADDR_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  rcs_pkg::in_item_t             item,
    input  logic [rcs_pkg::HOLD_W-1:0]    hold_ticks,
    input  logic                          power_enable,
    output rcs_pkg::out_item_t            result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RASL,
        PH_DATA,
        PH_COL,
        PH_CASL,
        PH_HOLD,
        PH_REL,
        PH_REF_RASL,
        PH_REF_RASH
    } phase_t;

    localparam logic [rcs_pkg::ADDR_W-1:0] ADDR_MASK =
        rcs_pkg::ADDR_W'((1 << ADDR_BITS) - 1);

    phase_t                          phase_reg, phase_next;
    logic [rcs_pkg::HOLD_W-1:0]      hold_count_reg, hold_count_next;
    logic [rcs_pkg::ADDR_W-1:0]      sweep_row_reg, sweep_row_next;
    logic [rcs_pkg::ADDR_W-1:0]      held_row_reg, held_row_next;
    logic [rcs_pkg::ADDR_W-1:0]      held_col_reg, held_col_next;
    logic                            held_data_reg, held_data_next;
    logic [rcs_pkg::OP_W-1:0]        held_op_reg, held_op_next;
    logic                            we_reg, we_next;
    logic                            din_reg, din_next;
    logic [rcs_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic                            ras_reg, ras_next;
    logic                            cas_reg, cas_next;
    logic                            rvalid;
    logic                            rbit;
    logic [rcs_pkg::HOLD_W-1:0]      hold_load;

    always_comb
    begin
        phase_next      = PH_IDLE;
        hold_count_next = hold_count_reg;
        sweep_row_next  = sweep_row_reg;
        held_row_next   = held_row_reg;
        held_col_next   = held_col_reg;
        held_data_next  = held_data_reg;
        held_op_next    = held_op_reg;
        we_next         = we_reg;
        din_next        = din_reg;
        addr_next       = addr_reg;
        ras_next        = ras_reg;
        cas_next        = cas_reg;
        rvalid          = 1'b0;
        rbit            = 1'b0;
        hold_load       = (hold_ticks != '0) ? hold_ticks - 1'b1 : '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req && (item.operation <= rcs_pkg::OP_REFRESH))
                begin
                    held_op_next   = item.operation;
                    held_row_next  = item.row_addr & ADDR_MASK;
                    held_col_next  = item.col_addr & ADDR_MASK;
                    held_data_next = item.write_bit;
                    ras_next       = 1'b1;
                    cas_next       = 1'b1;
                    if (item.operation == rcs_pkg::OP_REFRESH)
                    begin
                        sweep_row_next = '0;
                        addr_next      = '0;
                        phase_next     = PH_REF_RASL;
                    end
                    else
                    begin
                        if (item.operation == rcs_pkg::OP_READ)
                        begin
                            we_next = 1'b1;
                        end
                        addr_next  = item.row_addr & ADDR_MASK;
                        phase_next = PH_RASL;
                    end
                end
            end
            PH_RASL:
            begin
                ras_next   = 1'b0;
                phase_next = (held_op_reg == rcs_pkg::OP_WRITE) ? PH_DATA : PH_COL;
            end
            PH_DATA:
            begin
                we_next    = 1'b0;
                din_next   = held_data_reg;
                phase_next = PH_COL;
            end
            PH_COL:
            begin
                addr_next  = held_col_reg;
                phase_next = PH_CASL;
            end
            PH_CASL:
            begin
                cas_next        = 1'b0;
                hold_count_next = hold_load;
                phase_next      = (hold_load != '0) ? PH_HOLD : PH_REL;
            end
            PH_HOLD:
            begin
                if (hold_count_reg != '0)
                begin
                    hold_count_next = hold_count_reg - 1'b1;
                end
                phase_next = (hold_count_next != '0) ? PH_HOLD : PH_REL;
            end
            PH_REL:
            begin
                if (held_op_reg == rcs_pkg::OP_READ)
                begin
                    rvalid = 1'b1;
                    rbit   = item.dram_dout;
                end
                ras_next   = 1'b1;
                cas_next   = 1'b1;
                phase_next = PH_IDLE;
            end
            PH_REF_RASL:
            begin
                ras_next   = 1'b0;
                phase_next = PH_REF_RASH;
            end
            PH_REF_RASH:
            begin
                ras_next = 1'b1;
                if (sweep_row_reg >= ADDR_MASK)
                begin
                    sweep_row_next = '0;
                    phase_next     = PH_IDLE;
                end
                else
                begin
                    sweep_row_next = sweep_row_reg + 1'b1;
                    addr_next      = sweep_row_reg + 1'b1;
                    phase_next     = PH_REF_RASL;
                end
            end
            default:
            begin
                ras_next   = 1'b1;
                cas_next   = 1'b1;
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.ras_n      = ras_next;
        result.cas_n      = cas_next;
        result.we_n       = we_next;
        result.din        = din_next;
        result.addr_bus   = addr_next;
        result.power_pin  = power_enable;
        result.busy_res   = (phase_next != PH_IDLE);
        result.read_valid = rvalid;
        result.read_bit   = rbit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hold_count_reg <= '0;
            sweep_row_reg  <= '0;
            held_row_reg   <= '0;
            held_col_reg   <= '0;
            held_data_reg  <= 1'b0;
            held_op_reg    <= '0;
            we_reg         <= 1'b1;
            din_reg        <= 1'b0;
            addr_reg       <= '0;
            ras_reg        <= 1'b1;
            cas_reg        <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            hold_count_reg <= hold_count_next;
            sweep_row_reg  <= sweep_row_next;
            held_row_reg   <= held_row_next;
            held_col_reg   <= held_col_next;
            held_data_reg  <= held_data_next;
            held_op_reg    <= held_op_next;
            we_reg         <= we_next;
            din_reg        <= din_next;
            addr_reg       <= addr_next;
            ras_reg        <= ras_next;
            cas_reg        <= cas_next;
        end
    end

endmodule
